[hdl/cts_pkg.sv]
package cts_pkg;

  localparam int COUNT_WIDTH_DEF      = 16;
  localparam int VALUE_WIDTH_DEF      = 32;
  localparam int FRAC_DIGITS_KEPT_DEF = 9;
  localparam int KEYWORD_CHARS_DEF    = 8;

  localparam int KIND_W = 6;
  localparam int FRAC_W = 30;
  localparam int FCNT_W = 4;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_LINECOM, M_BLOCK, M_BLOCKSTAR, M_OP1, M_OP2, M_IDENT,
    M_NUMINT, M_NUMFRAC, M_CHAR1, M_CHAR2, M_STR, M_STRESC
  } mode_t;

  localparam logic [KIND_W-1:0] K_END    = 6'd0;
  localparam logic [KIND_W-1:0] K_TILDE  = 6'd44;
  localparam logic [KIND_W-1:0] K_CHAR   = 6'd45;
  localparam logic [KIND_W-1:0] K_STRING = 6'd46;
  localparam logic [KIND_W-1:0] K_NUMBER = 6'd57;
  localparam logic [KIND_W-1:0] K_IDENT  = 6'd58;
  localparam logic [KIND_W-1:0] K_DIVEQ  = 6'd20;
  localparam logic [KIND_W-1:0] K_DIV    = 6'd21;
  localparam logic [KIND_W-1:0] K_SHL_EQ = 6'd34;
  localparam logic [KIND_W-1:0] K_SHL    = 6'd36;
  localparam logic [KIND_W-1:0] K_SHR_EQ = 6'd38;
  localparam logic [KIND_W-1:0] K_SHR    = 6'd40;

  function automatic logic [KIND_W-1:0] sep_kind(input logic [7:0] c);
    case (c)
      8'h3B: return 6'd1;
      8'h2C: return 6'd2;
      8'h28: return 6'd3;
      8'h29: return 6'd4;
      8'h5B: return 6'd5;
      8'h5D: return 6'd6;
      8'h7B: return 6'd7;
      8'h7D: return 6'd8;
      8'h3A: return 6'd9;
      8'h2E: return 6'd10;
      default: return K_END;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] single_op(input logic [7:0] f);
    case (f)
      8'h2B: return 6'd13;
      8'h2D: return 6'd17;
      8'h2A: return 6'd19;
      8'h25: return 6'd23;
      8'h3D: return 6'd25;
      8'h26: return 6'd28;
      8'h7C: return 6'd31;
      8'h21: return 6'd33;
      8'h3C: return 6'd37;
      8'h3E: return 6'd41;
      8'h5E: return 6'd43;
      default: return K_END;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pair_op(input logic [7:0] f, input logic [7:0] c);
    logic eq;
    eq = (c == 8'h3D);
    case (f)
      8'h2B: return eq ? 6'd11 : (c == 8'h2B) ? 6'd12 : K_END;
      8'h2D: return eq ? 6'd14 : (c == 8'h2D) ? 6'd15 : (c == 8'h3E) ? 6'd16 : K_END;
      8'h2A: return eq ? 6'd18 : K_END;
      8'h25: return eq ? 6'd22 : K_END;
      8'h3D: return eq ? 6'd24 : K_END;
      8'h26: return (c == 8'h26) ? 6'd26 : eq ? 6'd27 : K_END;
      8'h7C: return (c == 8'h7C) ? 6'd29 : eq ? 6'd30 : K_END;
      8'h21: return eq ? 6'd32 : K_END;
      8'h3C: return eq ? 6'd35 : K_END;
      8'h3E: return eq ? 6'd39 : K_END;
      8'h5E: return eq ? 6'd42 : K_END;
      default: return K_END;
    endcase
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Token fields that travel from the scanner to the output stage.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              is_error;
    logic [31:0]       line;
    logic [31:0]       column;
    logic [31:0]       length;
    logic [63:0]       int_value;
    logic [FRAC_W-1:0] frac_digits;
    logic [FCNT_W-1:0] frac_count;
  } tok_t;

endpackage

[hdl/c_token_scanner_top.sv]
// channel | direction | ports
// input   | in        | in_valid, in_ready, in_ch, in_end_of_input
// result  | out       | out_valid, out_ready, out_kind .. out_last
// One byte is taken per cycle while in_ready is high; its tokens are in the output queue the next cycle.
// A byte gives up to two tokens; the four-entry output queue sets when input stalls.
// in_ready drops while fewer than two queue entries are free.
// rst_n is synchronous, active low, and returns the scanner to the start of a source.
module c_token_scanner_top
  import cts_pkg::*;
#(
  parameter int COUNT_WIDTH      = COUNT_WIDTH_DEF,
  parameter int VALUE_WIDTH      = VALUE_WIDTH_DEF,
  parameter int FRAC_DIGITS_KEPT = FRAC_DIGITS_KEPT_DEF,
  parameter int KEYWORD_CHARS    = KEYWORD_CHARS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_ch,
  input  logic                   in_end_of_input,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [KIND_W-1:0]      out_kind,
  output logic                   out_is_error,
  output logic [COUNT_WIDTH-1:0] out_start_line,
  output logic [COUNT_WIDTH-1:0] out_start_column,
  output logic [COUNT_WIDTH-1:0] out_length,
  output logic [VALUE_WIDTH-1:0] out_int_value,
  output logic [FRAC_W-1:0]      out_frac_digits,
  output logic [FCNT_W-1:0]      out_frac_count,
  output logic                   out_last
);

  logic step, v0, v1;
  tok_t t0, t1;

  assign step = in_valid && in_ready;

  cts_scanner #(
    .COUNT_WIDTH(COUNT_WIDTH), .VALUE_WIDTH(VALUE_WIDTH),
    .FRAC_DIGITS_KEPT(FRAC_DIGITS_KEPT), .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_scan (
    .clk(clk), .rst_n(rst_n), .step_i(step), .ch_i(in_ch), .eoi_i(in_end_of_input),
    .v0_o(v0), .t0_o(t0), .v1_o(v1), .t1_o(t1)
  );

  cts_out_queue #(.COUNT_WIDTH(COUNT_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)) u_q (
    .clk(clk), .rst_n(rst_n), .wr_i(step), .v0_i(v0), .t0_i(t0), .v1_i(v1), .t1_i(t1),
    .room_o(in_ready), .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .out_is_error(out_is_error), .out_start_line(out_start_line),
    .out_start_column(out_start_column), .out_length(out_length),
    .out_int_value(out_int_value), .out_frac_digits(out_frac_digits),
    .out_frac_count(out_frac_count), .out_last(out_last)
  );

endmodule

[hdl/cts_kw_match.sv]
module cts_kw_match
  import cts_pkg::*;
#(
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
  input  logic [KEYWORD_CHARS*8-1:0] buf_i,
  input  logic [COUNT_WIDTH-1:0]     len_i,
  output logic [KIND_W-1:0]          kind_o
);

  logic [63:0] w;

  // Compare the first eight buffered bytes (little end first) to each keyword.
  always_comb begin
    w = 64'(buf_i[63:0]);
    kind_o = K_IDENT;
    if (len_i == COUNT_WIDTH'(3) && w[23:0] == 24'h746E69) kind_o = 6'd47;
    if (len_i == COUNT_WIDTH'(5) && w[39:0] == 40'h74616F6C66) kind_o = 6'd48;
    if (len_i == COUNT_WIDTH'(6) && w[47:0] == 48'h656C62756F64) kind_o = 6'd49;
    if (len_i == COUNT_WIDTH'(4) && w[31:0] == 32'h72616863) kind_o = 6'd50;
    if (len_i == COUNT_WIDTH'(5) && w[39:0] == 40'h74736E6F63) kind_o = 6'd51;
    if (len_i == COUNT_WIDTH'(4) && w[31:0] == 32'h6D756E65) kind_o = 6'd52;
    if (len_i == COUNT_WIDTH'(4) && w[31:0] == 32'h64696F76) kind_o = 6'd53;
    if (len_i == COUNT_WIDTH'(8) && w == 64'h656C6974616C6F76) kind_o = 6'd54;
    if (len_i == COUNT_WIDTH'(5) && w[39:0] == 40'h6E6F696E75) kind_o = 6'd55;
    if (len_i == COUNT_WIDTH'(6) && w[47:0] == 48'h636974617473) kind_o = 6'd56;
  end

endmodule

[hdl/cts_scanner.sv]
module cts_scanner
  import cts_pkg::*;
#(
  parameter int COUNT_WIDTH      = COUNT_WIDTH_DEF,
  parameter int VALUE_WIDTH      = VALUE_WIDTH_DEF,
  parameter int FRAC_DIGITS_KEPT = FRAC_DIGITS_KEPT_DEF,
  parameter int KEYWORD_CHARS    = KEYWORD_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_i,
  input  logic [7:0] ch_i,
  input  logic       eoi_i,
  output logic       v0_o,
  output tok_t       t0_o,
  output logic       v1_o,
  output tok_t       t1_o
);

  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
  localparam logic [VALUE_WIDTH-1:0] VMAX = '1;
  localparam logic [VALUE_WIDTH-1:0] VLIM = VMAX / 10;
  localparam logic [3:0] VREM = 4'(VMAX % 10);
  localparam int KI_W = $clog2(KEYWORD_CHARS);

  mode_t mode_r, mode_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic [COUNT_WIDTH-1:0] line_r, line_nxt, col_r, col_nxt;
  logic [COUNT_WIDTH-1:0] tline_r, tline_nxt, tcol_r, tcol_nxt, tlen_r, tlen_nxt;
  logic [KEYWORD_CHARS*8-1:0] kw_r, kw_nxt;
  logic [VALUE_WIDTH-1:0] iacc_r, iacc_nxt;
  logic [FRAC_W-1:0] facc_r, facc_nxt;
  logic [FCNT_W-1:0] fcnt_r, fcnt_nxt;
  logic [KIND_W-1:0] kw_kind;
  logic [3:0] dig;
  logic redo;
  logic [KIND_W-1:0] k;

  cts_kw_match #(.KEYWORD_CHARS(KEYWORD_CHARS), .COUNT_WIDTH(COUNT_WIDTH)) u_kw (
    .buf_i(kw_r), .len_i(tlen_r), .kind_o(kw_kind)
  );

  function automatic logic [COUNT_WIDTH-1:0] sat(input logic [COUNT_WIDTH-1:0] x);
    return (x == CMAX) ? x : x + 1'b1;
  endfunction

  function automatic tok_t mk(input logic [KIND_W-1:0] kd, input logic er,
                              input logic [COUNT_WIDTH-1:0] ln,
                              input logic [COUNT_WIDTH-1:0] cl,
                              input logic [COUNT_WIDTH-1:0] lg);
    tok_t t;
    t = '0;
    t.kind = kd;
    t.is_error = er;
    t.line = 32'(ln);
    t.column = 32'(cl);
    t.length = 32'(lg);
    return t;
  endfunction

  // Next state and up to two tokens per byte.
  always_comb begin
    mode_nxt = mode_r; pend_nxt = pend_r; line_nxt = line_r; col_nxt = col_r;
    tline_nxt = tline_r; tcol_nxt = tcol_r; tlen_nxt = tlen_r; kw_nxt = kw_r;
    iacc_nxt = iacc_r; facc_nxt = facc_r; fcnt_nxt = fcnt_r;
    v0_o = 1'b0; v1_o = 1'b0; t0_o = '0; t1_o = '0;
    dig = ch_i[3:0] - 4'd0;
    redo = 1'b0;
    k = K_END;
    if (eoi_i || ch_i == 8'h00) begin
      // flush pending token, then end token, then reset
      v0_o = 1'b1;
      t0_o = mk(K_END, 1'b0, tline_r, tcol_r, tlen_r);
      unique case (mode_r)
        M_SLASH: t0_o.kind = K_DIV;
        M_BLOCK, M_BLOCKSTAR: begin
          t0_o.kind = K_IDENT; t0_o.is_error = 1'b1;
        end
        M_OP1: t0_o.kind = single_op(pend_r);
        M_OP2: t0_o.kind = (pend_r == 8'h3C) ? K_SHL : K_SHR;
        M_IDENT: t0_o.kind = kw_kind;
        M_NUMINT, M_NUMFRAC: begin
          t0_o.kind = K_NUMBER; t0_o.int_value = 64'(iacc_r);
          t0_o.frac_digits = facc_r; t0_o.frac_count = fcnt_r;
        end
        M_CHAR1, M_CHAR2: begin
          t0_o.kind = K_CHAR; t0_o.int_value = 64'(iacc_r);
        end
        M_STR, M_STRESC: t0_o.kind = K_STRING;
        default: v0_o = 1'b0;
      endcase
      if (v0_o) begin
        v1_o = 1'b1; t1_o = mk(K_END, 1'b0, line_r, col_r, '0);
      end else begin
        v0_o = 1'b1; t0_o = mk(K_END, 1'b0, line_r, col_r, '0);
      end
      mode_nxt = M_IDLE; pend_nxt = '0; line_nxt = COUNT_WIDTH'(1);
      col_nxt = COUNT_WIDTH'(1); tline_nxt = COUNT_WIDTH'(1);
      tcol_nxt = COUNT_WIDTH'(1); tlen_nxt = '0; kw_nxt = '0;
      iacc_nxt = '0; facc_nxt = '0; fcnt_nxt = '0;
    end else begin
      // Pass one: continue the pending token; redo sends the byte to idle.
      unique case (mode_r)
        M_SLASH: begin
          if (ch_i == 8'h2F) mode_nxt = M_LINECOM;
          else if (ch_i == 8'h2A) mode_nxt = M_BLOCK;
          else if (ch_i == 8'h3D) begin
            v0_o = 1'b1; t0_o = mk(K_DIVEQ, 1'b0, tline_r, tcol_r, sat(tlen_r));
            mode_nxt = M_IDLE;
          end else begin
            v0_o = 1'b1; t0_o = mk(K_DIV, 1'b0, tline_r, tcol_r, tlen_r); redo = 1'b1;
          end
        end
        M_LINECOM: if (ch_i == 8'h0A) mode_nxt = M_IDLE;
        M_BLOCK: if (ch_i == 8'h2A) mode_nxt = M_BLOCKSTAR;
        M_BLOCKSTAR: begin
          if (ch_i == 8'h2F) mode_nxt = M_IDLE;
          else if (ch_i != 8'h2A) mode_nxt = M_BLOCK;
        end
        M_OP1: begin
          k = pair_op(pend_r, ch_i);
          if ((pend_r == 8'h3C || pend_r == 8'h3E) && ch_i == pend_r) mode_nxt = M_OP2;
          else if (k != K_END) begin
            v0_o = 1'b1; t0_o = mk(k, 1'b0, tline_r, tcol_r, sat(tlen_r));
            mode_nxt = M_IDLE;
          end else begin
            v0_o = 1'b1; t0_o = mk(single_op(pend_r), 1'b0, tline_r, tcol_r, tlen_r);
            redo = 1'b1;
          end
        end
        M_OP2: begin
          v0_o = 1'b1;
          if (ch_i == 8'h3D) begin
            t0_o = mk((pend_r == 8'h3C) ? K_SHL_EQ : K_SHR_EQ, 1'b0, tline_r, tcol_r,
                      sat(tlen_r));
            mode_nxt = M_IDLE;
          end else begin
            t0_o = mk((pend_r == 8'h3C) ? K_SHL : K_SHR, 1'b0, tline_r, tcol_r, tlen_r);
            redo = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(ch_i) || is_digit(ch_i)) begin
            if (tlen_r < COUNT_WIDTH'(KEYWORD_CHARS))
              kw_nxt[8*tlen_r[KI_W-1:0] +: 8] = ch_i;
          end else begin
            v0_o = 1'b1; t0_o = mk(kw_kind, 1'b0, tline_r, tcol_r, tlen_r); redo = 1'b1;
          end
        end
        M_NUMINT, M_NUMFRAC: begin
          if (is_digit(ch_i) && mode_r == M_NUMINT) begin
            if (iacc_r > VLIM || (iacc_r == VLIM && dig > VREM)) iacc_nxt = VMAX;
            else iacc_nxt = VALUE_WIDTH'(iacc_r * 10) + VALUE_WIDTH'(dig);
          end else if (is_digit(ch_i)) begin
            if (fcnt_r < FCNT_W'(FRAC_DIGITS_KEPT)) begin
              facc_nxt = FRAC_W'(facc_r * 10) + FRAC_W'(dig);
              fcnt_nxt = fcnt_r + 1'b1;
            end
          end else if (ch_i == 8'h2E && mode_r == M_NUMINT) mode_nxt = M_NUMFRAC;
          else begin
            v0_o = 1'b1; t0_o = mk(K_NUMBER, 1'b0, tline_r, tcol_r, tlen_r);
            t0_o.int_value = 64'(iacc_r); t0_o.frac_digits = facc_r;
            t0_o.frac_count = fcnt_r; redo = 1'b1;
          end
        end
        M_CHAR1: begin
          iacc_nxt = VALUE_WIDTH'(ch_i); mode_nxt = M_CHAR2;
        end
        M_CHAR2: begin
          v0_o = 1'b1; t0_o = mk(K_CHAR, 1'b0, tline_r, tcol_r, sat(tlen_r));
          t0_o.int_value = 64'(iacc_r); mode_nxt = M_IDLE;
        end
        M_STR: begin
          if (ch_i == 8'h5C) mode_nxt = M_STRESC;
          else if (ch_i == 8'h22) begin
            v0_o = 1'b1; t0_o = mk(K_STRING, 1'b0, tline_r, tcol_r, sat(tlen_r));
            mode_nxt = M_IDLE;
          end
        end
        M_STRESC: mode_nxt = M_STR;
        default: redo = 1'b1;
      endcase
      if (!redo) tlen_nxt = sat(tlen_r);
      // Pass two: byte starts something from idle.
      if (redo) begin
        mode_nxt = M_IDLE;
        if (!is_space(ch_i)) begin
          tline_nxt = line_r; tcol_nxt = col_r; tlen_nxt = COUNT_WIDTH'(1);
          k = sep_kind(ch_i);
          if (k == K_END && ch_i == 8'h7E) k = K_TILDE;
          if (k != K_END || !(ch_i == 8'h2F || single_op(ch_i) != K_END ||
              ch_i == 8'h27 || ch_i == 8'h22 || is_digit(ch_i) || is_alpha(ch_i))) begin
            if (v0_o) begin
              v1_o = 1'b1;
              t1_o = mk((k == K_END) ? K_IDENT : k, k == K_END, line_r, col_r,
                        COUNT_WIDTH'(1));
            end else begin
              v0_o = 1'b1;
              t0_o = mk((k == K_END) ? K_IDENT : k, k == K_END, line_r, col_r,
                        COUNT_WIDTH'(1));
            end
          end else if (ch_i == 8'h2F) mode_nxt = M_SLASH;
          else if (single_op(ch_i) != K_END) begin
            pend_nxt = ch_i; mode_nxt = M_OP1;
          end else if (ch_i == 8'h27) begin
            iacc_nxt = '0; mode_nxt = M_CHAR1;
          end else if (ch_i == 8'h22) mode_nxt = M_STR;
          else if (is_digit(ch_i)) begin
            iacc_nxt = VALUE_WIDTH'(dig); facc_nxt = '0; fcnt_nxt = '0;
            mode_nxt = M_NUMINT;
          end else begin
            kw_nxt = '0; kw_nxt[7:0] = ch_i; mode_nxt = M_IDENT;
          end
        end else begin
          tlen_nxt = sat(tlen_r);
        end
      end
      // Track position.
      if (ch_i == 8'h0A) begin
        line_nxt = sat(line_r); col_nxt = COUNT_WIDTH'(1);
      end else begin
        col_nxt = sat(col_r);
      end
    end
  end

  // Hold state between transfers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; pend_r <= '0; line_r <= COUNT_WIDTH'(1);
      col_r <= COUNT_WIDTH'(1); tline_r <= COUNT_WIDTH'(1);
      tcol_r <= COUNT_WIDTH'(1); tlen_r <= '0; kw_r <= '0;
      iacc_r <= '0; facc_r <= '0; fcnt_r <= '0;
    end else if (step_i) begin
      mode_r <= mode_nxt; pend_r <= pend_nxt; line_r <= line_nxt; col_r <= col_nxt;
      tline_r <= tline_nxt; tcol_r <= tcol_nxt; tlen_r <= tlen_nxt; kw_r <= kw_nxt;
      iacc_r <= iacc_nxt; facc_r <= facc_nxt; fcnt_r <= fcnt_nxt;
    end
  end

endmodule

[hdl/cts_out_queue.sv]
module cts_out_queue
  import cts_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_i,
  input  logic                   v0_i,
  input  tok_t                   t0_i,
  input  logic                   v1_i,
  input  tok_t                   t1_i,
  output logic                   room_o,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [KIND_W-1:0]      out_kind,
  output logic                   out_is_error,
  output logic [COUNT_WIDTH-1:0] out_start_line,
  output logic [COUNT_WIDTH-1:0] out_start_column,
  output logic [COUNT_WIDTH-1:0] out_length,
  output logic [VALUE_WIDTH-1:0] out_int_value,
  output logic [FRAC_W-1:0]      out_frac_digits,
  output logic [FCNT_W-1:0]      out_frac_count,
  output logic                   out_last
);

  // Four-entry circular queue; one byte adds at most two entries.
  tok_t       q_r [4];
  logic       ql_r [4];
  logic [1:0] rd_r, rd_nxt, wp;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop = out_valid && out_ready;
  assign room_o = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign wp = rd_r + cnt_r[1:0];

  always_comb begin
    rd_nxt = rd_r + 2'(pop);
    cnt_nxt = cnt_r - 3'(pop);
    if (wr_i) cnt_nxt = cnt_nxt + 3'(v0_i) + 3'(v1_i);
  end

  // Advance pointers; push new tokens.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0; cnt_r <= '0;
    end else begin
      rd_r <= rd_nxt; cnt_r <= cnt_nxt;
    end
    if (wr_i && v0_i) begin
      q_r[wp] <= t0_i; ql_r[wp] <= !v1_i;
    end
    if (wr_i && v1_i) begin
      q_r[wp + 2'd1] <= t1_i; ql_r[wp + 2'd1] <= 1'b1;
    end
  end

  assign out_kind         = q_r[rd_r].kind;
  assign out_is_error     = q_r[rd_r].is_error;
  assign out_start_line   = COUNT_WIDTH'(q_r[rd_r].line);
  assign out_start_column = COUNT_WIDTH'(q_r[rd_r].column);
  assign out_length       = COUNT_WIDTH'(q_r[rd_r].length);
  assign out_int_value    = VALUE_WIDTH'(q_r[rd_r].int_value);
  assign out_frac_digits  = q_r[rd_r].frac_digits;
  assign out_frac_count   = q_r[rd_r].frac_count;
  assign out_last         = ql_r[rd_r];

endmodule

[hdl/cts_checker.sv]
module cts_checker
  import cts_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_kind,
  input logic              out_is_error,
  input logic              out_last
);

  // An end token always closes its byte's results.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_END |-> out_last) else $error("end token not last");

  // Errors are only reported as identifier kind.
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_error |-> out_kind == K_IDENT) else $error("error kind");

  // Nothing comes out the cycle after reset.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("output after reset");

  // Held result must stay valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // An empty queue always takes the next byte.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("input blocked while empty");

endmodule

bind c_token_scanner_top cts_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
  .out_is_error(out_is_error), .out_last(out_last)
);

[sim/tb_top.sv]
module tb_top;
  import cts_pkg::*;

  localparam int CNT_MAX  = 65535;
  localparam int KW_CHARS = 8;
  localparam int FRAC_MAX = 9;
  localparam int WD_LIMIT = 20000;

  typedef struct {
    logic [5:0]  kind;
    logic        is_error;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] length;
    logic [31:0] int_value;
    logic [29:0] frac_digits;
    logic [3:0]  frac_count;
    logic        last;
  } token_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_ch;
  logic        in_end_of_input;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  out_kind;
  logic        out_is_error;
  logic [15:0] out_start_line;
  logic [15:0] out_start_column;
  logic [15:0] out_length;
  logic [31:0] out_int_value;
  logic [29:0] out_frac_digits;
  logic [3:0]  out_frac_count;
  logic        out_last;

  c_token_scanner_top dut (.*);

  // scanner copy of state
  mode_t      sc_mode;
  logic [7:0] sc_pend;
  int unsigned sc_line, sc_col, tk_line, tk_col, tk_len;
  logic [7:0] kw_buf [KW_CHARS];
  logic [31:0] acc_int;
  logic [29:0] acc_frac;
  int unsigned acc_fcnt;

  token_t expected_tokens[$];
  token_t step_toks[$];
  int     fail_count;
  int     send_idle_pct;
  int     recv_idle_pct;
  bit     recv_hold;
  int     hold_cycles;
  int     quiet_cycles;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned sat_inc(int unsigned x);
    return (x < CNT_MAX) ? x + 1 : CNT_MAX;
  endfunction

  function automatic logic [5:0] op_single(logic [7:0] f);
    case (f)
      "+": return 13; "-": return 17; "*": return 19; "%": return 23;
      "=": return 25; "&": return 28; "|": return 31; "!": return 33;
      "<": return 37; ">": return 41; "^": return 43;
      default: return K_END;
    endcase
  endfunction

  function automatic logic [5:0] op_pair(logic [7:0] f, logic [7:0] c);
    case (f)
      "+": return c == "=" ? 11 : c == "+" ? 12 : 0;
      "-": return c == "=" ? 14 : c == "-" ? 15 : c == ">" ? 16 : 0;
      "*": return c == "=" ? 18 : 0;
      "%": return c == "=" ? 22 : 0;
      "=": return c == "=" ? 24 : 0;
      "&": return c == "&" ? 26 : c == "=" ? 27 : 0;
      "|": return c == "|" ? 29 : c == "=" ? 30 : 0;
      "!": return c == "=" ? 32 : 0;
      "<": return c == "=" ? 35 : 0;
      ">": return c == "=" ? 39 : 0;
      "^": return c == "=" ? 42 : 0;
      default: return 0;
    endcase
  endfunction

  function automatic logic [5:0] sep_code(logic [7:0] c);
    case (c)
      ";": return 1; ",": return 2; "(": return 3; ")": return 4; "[": return 5;
      "]": return 6; "{": return 7; "}": return 8; ":": return 9; ".": return 10;
      default: return K_END;
    endcase
  endfunction

  function automatic bit alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit space_c(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [5:0] word_kind();
    string words[10];
    int i, k;
    bit ok;
    words = '{"int", "float", "double", "char", "const", "enum", "void", "volatile",
              "union", "static"};
    if (tk_len > KW_CHARS) return K_IDENT;
    for (k = 0; k < 10; k++) begin
      if (words[k].len() != tk_len) continue;
      ok = 1;
      for (i = 0; i < words[k].len(); i++)
        if (kw_buf[i] != words[k][i]) ok = 0;
      if (ok) return 6'(47 + k);
    end
    return K_IDENT;
  endfunction

  function automatic void emit(logic [5:0] k, logic err, logic [31:0] iv = 0,
                               logic [29:0] fd = 0, logic [3:0] fc = 0);
    token_t t;
    t.kind = k; t.is_error = err; t.start_line = tk_line[15:0];
    t.start_column = tk_col[15:0]; t.length = tk_len[15:0];
    t.int_value = iv; t.frac_digits = fd; t.frac_count = fc; t.last = 0;
    step_toks.push_back(t);
  endfunction

  function automatic void bump(logic [7:0] c);
    if (c == 8'd10) begin
      sc_line = sat_inc(sc_line);
      sc_col = 1;
    end else begin
      sc_col = sat_inc(sc_col);
    end
    tk_len = sat_inc(tk_len);
  endfunction

  function automatic void scanner_reset();
    sc_mode = M_IDLE; sc_pend = 0; sc_line = 1; sc_col = 1;
    tk_line = 1; tk_col = 1; tk_len = 0;
    foreach (kw_buf[i]) kw_buf[i] = 0;
    acc_int = 0; acc_frac = 0; acc_fcnt = 0;
  endfunction

  function automatic void start_byte(logic [7:0] c);
    if (space_c(c)) begin
      bump(c);
      return;
    end
    tk_line = sc_line; tk_col = sc_col; tk_len = 0;
    bump(c);
    if (sep_code(c) != K_END) emit(sep_code(c), 0);
    else if (c == "~") emit(K_TILDE, 0);
    else if (c == "/") sc_mode = M_SLASH;
    else if (op_single(c) != K_END) begin
      sc_pend = c; sc_mode = M_OP1;
    end else if (c == "'") begin
      acc_int = 0; sc_mode = M_CHAR1;
    end else if (c == "\"") sc_mode = M_STR;
    else if (digit_c(c)) begin
      acc_int = c - "0"; acc_frac = 0; acc_fcnt = 0; sc_mode = M_NUMINT;
    end else if (alpha_c(c)) begin
      foreach (kw_buf[i]) kw_buf[i] = 0;
      kw_buf[0] = c; sc_mode = M_IDENT;
    end else emit(K_IDENT, 1);
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    logic [5:0] k;
    logic [63:0] wide;
    forever begin
      case (sc_mode)
        M_SLASH: begin
          if (c == "/") begin bump(c); sc_mode = M_LINECOM; return; end
          if (c == "*") begin bump(c); sc_mode = M_BLOCK; return; end
          if (c == "=") begin bump(c); emit(K_DIVEQ, 0); sc_mode = M_IDLE; return; end
          emit(K_DIV, 0); sc_mode = M_IDLE;
        end
        M_LINECOM: begin
          bump(c);
          if (c == 8'd10) sc_mode = M_IDLE;
          return;
        end
        M_BLOCK: begin
          bump(c);
          if (c == "*") sc_mode = M_BLOCKSTAR;
          return;
        end
        M_BLOCKSTAR: begin
          bump(c);
          if (c == "/") sc_mode = M_IDLE;
          else if (c != "*") sc_mode = M_BLOCK;
          return;
        end
        M_OP1: begin
          if ((sc_pend == "<" || sc_pend == ">") && c == sc_pend) begin
            bump(c); sc_mode = M_OP2; return;
          end
          k = op_pair(sc_pend, c);
          if (k != 0) begin bump(c); emit(k, 0); sc_mode = M_IDLE; return; end
          emit(op_single(sc_pend), 0); sc_mode = M_IDLE;
        end
        M_OP2: begin
          if (c == "=") begin
            bump(c); emit(sc_pend == "<" ? K_SHL_EQ : K_SHR_EQ, 0);
            sc_mode = M_IDLE; return;
          end
          emit(sc_pend == "<" ? K_SHL : K_SHR, 0); sc_mode = M_IDLE;
        end
        M_IDENT: begin
          if (alpha_c(c) || digit_c(c)) begin
            if (tk_len < KW_CHARS) kw_buf[tk_len] = c;
            bump(c); return;
          end
          emit(word_kind(), 0); sc_mode = M_IDLE;
        end
        M_NUMINT: begin
          if (digit_c(c)) begin
            wide = 64'(acc_int) * 10 + (c - "0");
            acc_int = wide > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : wide[31:0];
            bump(c); return;
          end
          if (c == ".") begin bump(c); sc_mode = M_NUMFRAC; return; end
          emit(K_NUMBER, 0, acc_int, acc_frac, acc_fcnt); sc_mode = M_IDLE;
        end
        M_NUMFRAC: begin
          if (digit_c(c)) begin
            if (acc_fcnt < FRAC_MAX) begin
              acc_frac = acc_frac * 10 + (c - "0"); acc_fcnt++;
            end
            bump(c); return;
          end
          emit(K_NUMBER, 0, acc_int, acc_frac, acc_fcnt); sc_mode = M_IDLE;
        end
        M_CHAR1: begin
          acc_int = c; bump(c); sc_mode = M_CHAR2; return;
        end
        M_CHAR2: begin
          bump(c); emit(K_CHAR, 0, acc_int); sc_mode = M_IDLE; return;
        end
        M_STR: begin
          bump(c);
          if (c == "\\") sc_mode = M_STRESC;
          else if (c == "\"") begin emit(K_STRING, 0); sc_mode = M_IDLE; end
          return;
        end
        M_STRESC: begin
          bump(c); sc_mode = M_STR; return;
        end
        default: begin
          sc_mode = M_IDLE; start_byte(c); return;
        end
      endcase
    end
  endfunction

  function automatic void flush_source();
    case (sc_mode)
      M_SLASH: emit(K_DIV, 0);
      M_BLOCK, M_BLOCKSTAR: emit(K_IDENT, 1);
      M_OP1: emit(op_single(sc_pend), 0);
      M_OP2: emit(sc_pend == "<" ? K_SHL : K_SHR, 0);
      M_IDENT: emit(word_kind(), 0);
      M_NUMINT, M_NUMFRAC: emit(K_NUMBER, 0, acc_int, acc_frac, acc_fcnt);
      M_CHAR1, M_CHAR2: emit(K_CHAR, 0, acc_int);
      M_STR, M_STRESC: emit(K_STRING, 0);
      default: ;
    endcase
    tk_line = sc_line; tk_col = sc_col; tk_len = 0;
    emit(K_END, 0);
    scanner_reset();
  endfunction

  // Predict the tokens of one byte and queue them.
  function automatic void predict_tokens(logic [7:0] c, logic eoi);
    step_toks.delete();
    if (eoi || c == 0) flush_source();
    else scan_byte(c);
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1;
    foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
  endfunction

  // Offer one byte; valid stays up after the transfer until the next idle or drain.
  task automatic send_byte(logic [7:0] c, logic eoi = 0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_ch <= c;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tokens(c, eoi);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_tokens.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sample results and compare against the oldest prediction.
  always @(posedge clk) begin
    token_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        $error("token with nothing expected: kind %0d", out_kind);
        fail_count++;
      end else begin
        e = expected_tokens.pop_front();
        if (out_kind !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, out_kind); fail_count++;
        end
        if (out_is_error !== e.is_error) begin
          $error("is_error exp %0d got %0d", e.is_error, out_is_error); fail_count++;
        end
        if (out_start_line !== e.start_line) begin
          $error("start_line exp %0d got %0d", e.start_line, out_start_line);
          fail_count++;
        end
        if (out_start_column !== e.start_column) begin
          $error("start_column exp %0d got %0d", e.start_column, out_start_column);
          fail_count++;
        end
        if (out_length !== e.length) begin
          $error("length exp %0d got %0d", e.length, out_length); fail_count++;
        end
        if (out_int_value !== e.int_value) begin
          $error("int_value exp %0d got %0d", e.int_value, out_int_value); fail_count++;
        end
        if (out_frac_digits !== e.frac_digits) begin
          $error("frac_digits exp %0d got %0d", e.frac_digits, out_frac_digits);
          fail_count++;
        end
        if (out_frac_count !== e.frac_count) begin
          $error("frac_count exp %0d got %0d", e.frac_count, out_frac_count);
          fail_count++;
        end
        if (out_last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_last); fail_count++;
        end
      end
    end
  end

  // Drive ready with random stalls and one long hold-off.
  always @(posedge clk) begin
    if (recv_hold && hold_cycles < 60) begin
      hold_cycles <= hold_cycles + 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on transfers.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_separators_ops();
    send_text("; , ( ) [ ] { } : . ~ += ++ + -= -- -> - *= * /= / %= % == = ");
    send_text("&& &= & || |= | != ! <<= <= << < >>= >= >> > ^= ^ @");
    send_byte(0, 1);
  endtask

  task automatic test_words_numbers();
    send_text("int float double char const enum void volatile union static ");
    send_text("integer vol _x9 99999999999 3.14159265358979 7. 0\n");
    send_text("'a' '\\n' \"s\\\"q\" /* c */ // line\n x/*open");
    send_byte(8'hFF, 1);
    send_text("'q");
    send_byte(0);
    send_text("\"abc");
    send_byte(0, 1);
  endtask

  task automatic test_long_stall();
    recv_hold = 1;
    hold_cycles = 0;
    send_text("a+b;c<<=d>>e;f");
    recv_hold = 0;
    drain();
  endtask

  task automatic test_random_source(int n);
    string frags[16];
    string f;
    int i;
    frags = '{"int ", "x1", " = ", "42", "3.5", ";\n", "/* z */", "// q\n",
              "'c'", "\"s\\\"\"", "<<=", "->", "volatile", "(", ")", "{ }"};
    i = 0;
    while (i < n) begin
      if ($urandom_range(9) < 7) begin
        f = frags[$urandom_range(15)];
        send_text(f);
        i += f.len();
      end else begin
        send_byte(8'($urandom_range(1, 255)));
        i++;
      end
      if ($urandom_range(99) == 0) begin
        send_byte(8'($urandom), 1);
        i++;
      end
    end
    send_byte(0, 1);
  endtask

  initial begin
    fail_count = 0;
    rst_n = 0;
    in_valid = 0;
    in_ch = 0;
    in_end_of_input = 0;
    out_ready = 0;
    recv_hold = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    send_idle_pct = 16;
    recv_idle_pct = 51;
    scanner_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_separators_ops();
    test_words_numbers();
    test_long_stall();
    test_random_source(200);
    send_idle_pct = 51;
    recv_idle_pct = 16;
    test_random_source(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_source(200);
    drain();
    if (fail_count == 0 && expected_tokens.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/cts_pkg.sv
hdl/cts_kw_match.sv
hdl/cts_scanner.sv
hdl/cts_out_queue.sv
hdl/c_token_scanner_top.sv
hdl/cts_checker.sv
sim/tb_top.sv
